>>> hdl/spq_pkg.sv
// Shared types and constants for the sprite part quad setup block.
package spq_pkg;

   localparam int unsigned COORD_W     = 16;
   localparam int unsigned TEX_W       = 8;
   localparam int unsigned PAL_W       = 16;
   localparam int unsigned FLAGS_W     = 6;
   localparam int unsigned VTX_W       = 2;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FACES_LEFT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_BASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_BASE   = 3'd4;

   // Bit positions of part_flags.
   localparam int unsigned FLAG_VFLIP  = 0;
   localparam int unsigned FLAG_HFLIP  = 1;
   localparam int unsigned FLAG_TRIM_R = 2;
   localparam int unsigned FLAG_TRIM_B = 3;
   localparam int unsigned FLAG_TRIM_L = 4;
   localparam int unsigned FLAG_TRIM_T = 5;

   localparam logic [VTX_W-1:0] VTX_LAST = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic               faces_left;
      logic [PAL_W-1:0]   palette_base;
      logic [PAL_W-1:0]   depth_base;
   } cfg_type;

   // One classified part, ready for vertex generation.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic               faces_left;
      logic [TEX_W-1:0]   ul;
      logic [TEX_W-1:0]   ur;
      logic [TEX_W-1:0]   vt;
      logic [TEX_W-1:0]   vb;
      logic [PAL_W-1:0]   pal;
      logic [PAL_W-1:0]   prio;
   } quad_type;

endpackage

>>> hdl/spq_front.sv
// Front end: applies trims and flips to a part record and builds a quad record.
module spq_front
   import spq_pkg::*;
(
   input  cfg_type            cfg,
   input  logic [FLAGS_W-1:0] part_flags,
   input  logic [COORD_W-1:0] offset_x,
   input  logic [COORD_W-1:0] offset_y,
   input  logic [COORD_W-1:0] width,
   input  logic [COORD_W-1:0] height,
   input  logic [PAL_W-1:0]   palette_offset,
   input  logic [TEX_W-1:0]   tex_left,
   input  logic [TEX_W-1:0]   tex_top,
   input  logic [TEX_W-1:0]   tex_right,
   input  logic [TEX_W-1:0]   tex_bottom,
   output quad_type           quad
);

   logic               vf, hf, tr, tb, tl, tt, hflip;
   logic [COORD_W-1:0] dx_t, dy_t;
   logic [TEX_W-1:0]   u0_t, u1_t, v0_t, v1_t;

   assign vf = part_flags[FLAG_VFLIP];
   assign hf = part_flags[FLAG_HFLIP];
   assign tr = part_flags[FLAG_TRIM_R];
   assign tb = part_flags[FLAG_TRIM_B];
   assign tl = part_flags[FLAG_TRIM_L];
   assign tt = part_flags[FLAG_TRIM_T];
   assign hflip = hf | cfg.faces_left;

   // A trimmed edge moves the origin only when it is the leading edge after flip.
   assign dx_t = offset_x + COORD_W'(tr & hf) + COORD_W'(tl & ~hf);
   assign dy_t = offset_y + COORD_W'(tb & vf) + COORD_W'(tt & ~vf);

   assign u0_t = tex_left + TEX_W'(tl);
   assign u1_t = tex_right - TEX_W'(tr);
   assign v0_t = tex_top + TEX_W'(tt);
   assign v1_t = tex_bottom - TEX_W'(tb);

   always_comb begin
      quad.x = cfg.faces_left ? (cfg.origin_x - dx_t) : (cfg.origin_x + dx_t);
      quad.y = cfg.origin_y + dy_t;
      quad.w = width - COORD_W'(tr) - COORD_W'(tl);
      quad.h = height - COORD_W'(tb) - COORD_W'(tt);
      quad.faces_left = cfg.faces_left;
      quad.ul = hflip ? (u1_t - TEX_W'(1)) : u0_t;
      quad.ur = hflip ? (u0_t - TEX_W'(1)) : u1_t;
      quad.vt = vf ? (v1_t - TEX_W'(1)) : v0_t;
      quad.vb = vf ? (v0_t - TEX_W'(1)) : v1_t;
      quad.pal = cfg.palette_base + palette_offset;
      quad.prio = cfg.depth_base + PAL_W'(1);
   end

endmodule

>>> hdl/spq_queue.sv
// Small FIFO of quad records between the front end and the vertex generator.
module spq_queue
   import spq_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  quad_type push_data,
   input  logic     pop,
   output quad_type pop_data,
   output logic     empty,
   output logic     full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   quad_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty    = (count_ff == CNT_W'(0));
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/spq_back.sv
// Back end: walks the four corners of each queued quad and registers one vertex a cycle.
module spq_back
   import spq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  quad_type           q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic [VTX_W-1:0]   rsp_vertex_index,
   output logic [COORD_W-1:0] rsp_screen_x,
   output logic [COORD_W-1:0] rsp_screen_y,
   output logic [TEX_W-1:0]   rsp_tex_u,
   output logic [TEX_W-1:0]   rsp_tex_v,
   output logic [PAL_W-1:0]   rsp_palette_out,
   output logic [PAL_W-1:0]   rsp_priority_out,
   output logic               rsp_quad_done,
   output logic               active
);

   quad_type           cur_ff;
   logic               active_ff;
   logic [VTX_W-1:0]   cnt_ff;
   logic [COORD_W-1:0] xl, xr, yb;

   logic               valid_ff;
   logic [VTX_W-1:0]   index_ff;
   logic [COORD_W-1:0] screen_x_ff, screen_y_ff;
   logic [COORD_W-1:0] screen_x_in, screen_y_in;
   logic [TEX_W-1:0]   tex_u_ff, tex_v_ff, tex_u_in, tex_v_in;
   logic [PAL_W-1:0]   pal_ff, prio_ff;
   logic               done_ff;

   // Take the next quad when idle or on the last corner of the current one.
   assign q_pop  = !q_empty && (!active_ff || (cnt_ff == VTX_LAST));
   assign active = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (q_pop) begin
         active_ff <= 1'b1;
         cnt_ff    <= '0;
      end else if (active_ff) begin
         cnt_ff <= cnt_ff + VTX_W'(1);
         if (cnt_ff == VTX_LAST) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
   end

   // A left-facing quad is mirrored about the origin column.
   assign xl = cur_ff.faces_left ? (cur_ff.x - cur_ff.w + COORD_W'(1)) : cur_ff.x;
   assign xr = cur_ff.faces_left ? (cur_ff.x + COORD_W'(1)) : (cur_ff.x + cur_ff.w);
   assign yb = cur_ff.y + cur_ff.h;

   always_comb begin
      screen_x_in = cnt_ff[0] ? xr : xl;
      screen_y_in = cnt_ff[1] ? yb : cur_ff.y;
      tex_u_in    = cnt_ff[0] ? cur_ff.ur : cur_ff.ul;
      tex_v_in    = cnt_ff[1] ? cur_ff.vb : cur_ff.vt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      index_ff    <= cnt_ff;
      screen_x_ff <= screen_x_in;
      screen_y_ff <= screen_y_in;
      tex_u_ff    <= tex_u_in;
      tex_v_ff    <= tex_v_in;
      pal_ff      <= cur_ff.pal;
      prio_ff     <= cur_ff.prio;
      done_ff     <= (cnt_ff == VTX_LAST);
   end

   assign rsp_valid        = valid_ff;
   assign rsp_vertex_index = index_ff;
   assign rsp_screen_x     = screen_x_ff;
   assign rsp_screen_y     = screen_y_ff;
   assign rsp_tex_u        = tex_u_ff;
   assign rsp_tex_v        = tex_v_ff;
   assign rsp_palette_out  = pal_ff;
   assign rsp_priority_out = prio_ff;
   assign rsp_quad_done    = done_ff;

endmodule

>>> hdl/sprite_part_quad_setup.sv
// Top level of the sprite part quad setup block.
//
// Usage: a part record is taken on a rising edge where start is high and busy
// is low; the fields sit on the req_ ports. Each part produces four vertex
// transactions on the rsp_ ports in order top-left, top-right, bottom-left,
// bottom-right, each shown for one cycle with rsp_valid high; rsp_quad_done
// marks the fourth. The receiver cannot stall, so vertices leave one a cycle.
// An accepted part is written into the queue, loaded into the current-quad
// register of a free vertex generator and its first vertex registered onto
// the rsp_ ports. The generator takes the next part on the last corner of the
// current one. A queue of QUEUE_DEPTH classified parts sits between the front
// end and the vertex generator; busy is high while that queue is full.
// Configuration: csr_we writes csr_wdata into register csr_index
// (0 origin_x, 1 origin_y, 2 faces_left, 3 palette_base, 4 depth_base) at a
// rising edge; other indexes are ignored. Write only while the block is idle.
// Reset (synchronous, active high) clears the configuration registers, empties the queue
// and stops any vertex sequence in flight.
module sprite_part_quad_setup
   import spq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [FLAGS_W-1:0]        req_part_flags,
   input  logic signed [COORD_W-1:0] req_offset_x,
   input  logic signed [COORD_W-1:0] req_offset_y,
   input  logic signed [COORD_W-1:0] req_width,
   input  logic signed [COORD_W-1:0] req_height,
   input  logic [PAL_W-1:0]          req_palette_offset,
   input  logic [TEX_W-1:0]          req_tex_left,
   input  logic [TEX_W-1:0]          req_tex_top,
   input  logic [TEX_W-1:0]          req_tex_right,
   input  logic [TEX_W-1:0]          req_tex_bottom,
   output logic                      rsp_valid,
   output logic [VTX_W-1:0]          rsp_vertex_index,
   output logic signed [COORD_W-1:0] rsp_screen_x,
   output logic signed [COORD_W-1:0] rsp_screen_y,
   output logic [TEX_W-1:0]          rsp_tex_u,
   output logic [TEX_W-1:0]          rsp_tex_v,
   output logic [PAL_W-1:0]          rsp_palette_out,
   output logic [PAL_W-1:0]          rsp_priority_out,
   output logic                      rsp_quad_done,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type            cfg_ff;
   quad_type           front_quad, q_data;
   logic               push, q_pop, q_empty, q_full, back_active;
   logic [COORD_W-1:0] screen_x, screen_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:     cfg_ff.origin_x     <= csr_wdata[COORD_W-1:0];
            CSR_ORIGIN_Y:     cfg_ff.origin_y     <= csr_wdata[COORD_W-1:0];
            CSR_FACES_LEFT:   cfg_ff.faces_left   <= csr_wdata[0];
            CSR_PALETTE_BASE: cfg_ff.palette_base <= csr_wdata[PAL_W-1:0];
            CSR_DEPTH_BASE:   cfg_ff.depth_base   <= csr_wdata[PAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = q_full;
   assign push = start && !busy;

   spq_front u_front (
      .cfg            (cfg_ff),
      .part_flags     (req_part_flags),
      .offset_x       (req_offset_x),
      .offset_y       (req_offset_y),
      .width          (req_width),
      .height         (req_height),
      .palette_offset (req_palette_offset),
      .tex_left       (req_tex_left),
      .tex_top        (req_tex_top),
      .tex_right      (req_tex_right),
      .tex_bottom     (req_tex_bottom),
      .quad           (front_quad)
   );

   spq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_quad),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   spq_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_screen_x     (screen_x),
      .rsp_screen_y     (screen_y),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_palette_out  (rsp_palette_out),
      .rsp_priority_out (rsp_priority_out),
      .rsp_quad_done    (rsp_quad_done),
      .active           (back_active)
   );

   assign rsp_screen_x = screen_x;
   assign rsp_screen_y = screen_y;

   // A vertex other than the last is always followed by the next corner.
   a_corner_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_vertex_index != VTX_LAST) |=>
         rsp_valid && (rsp_vertex_index == $past(rsp_vertex_index) + VTX_W'(1)))
      else $error("vertex sequence broken");

   // A later corner only ever follows an earlier one of the same quad.
   a_no_orphan_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_vertex_index != '0) |-> $past(rsp_valid))
      else $error("vertex emitted without its predecessor");

   // An accepted transaction leaves the queue occupied or the generator running.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !q_empty || back_active)
      else $error("accepted transaction lost");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the sprite part quad setup block.
module tb;
   import spq_pkg::*;

   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [PAL_W-1:0]   pal_ofs;
      logic [TEX_W-1:0]   tex_l;
      logic [TEX_W-1:0]   tex_t;
      logic [TEX_W-1:0]   tex_r;
      logic [TEX_W-1:0]   tex_b;
   } part_rec_type;

   typedef struct packed {
      logic [COORD_W-1:0] xl;
      logic [COORD_W-1:0] xr;
      logic [COORD_W-1:0] yt;
      logic [COORD_W-1:0] yb;
      logic [TEX_W-1:0]   ul;
      logic [TEX_W-1:0]   ur;
      logic [TEX_W-1:0]   vt;
      logic [TEX_W-1:0]   vb;
      logic [PAL_W-1:0]   pal;
      logic [PAL_W-1:0]   prio;
   } corners_type;

   typedef struct packed {
      logic [VTX_W-1:0]   idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [TEX_W-1:0]   u;
      logic [TEX_W-1:0]   v;
      logic [PAL_W-1:0]   pal;
      logic [PAL_W-1:0]   prio;
      logic               done;
   } vertex_type;

   typedef struct packed {
      logic         set_cfg;
      cfg_type      cfg;
      part_rec_type part;
      logic         typed;
      corners_type  want;
   } row_type;

   localparam int unsigned LIMIT_CYCLES    = 200000;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned PARTS_PER_PHASE = 50;
   localparam int unsigned MAX_GAP         = 13;
   localparam int unsigned REPORT_LIMIT    = 10;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned NUM_DIRECTED    = 21;

   localparam cfg_type CFG_ZERO     = '0;
   localparam cfg_type CFG_WRAP     = '{16'h0000, 16'h0000, 1'b0, 16'h0001, 16'hFFFF};
   localparam cfg_type CFG_MIRROR   = '{16'd100, 16'd50, 1'b1, 16'h1234, 16'h00FF};
   localparam cfg_type CFG_EDGE_MAX = '{16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF, 16'hFFFF};
   localparam cfg_type CFG_EDGE_MIN = '{16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000};

   localparam part_rec_type PART_MAX =
      '{6'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
   localparam part_rec_type PART_MIN =
      '{6'h00, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00};

   // Size 8x8 at offset zero, texture 0x10..0x30 by 0x20..0x40.
   function automatic part_rec_type std_part(logic [FLAGS_W-1:0] flags);
      std_part = '{flags, 16'h0000, 16'h0000, 16'h0008, 16'h0008, 16'h0000,
                   8'h10, 8'h20, 8'h30, 8'h40};
   endfunction

   localparam row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{1'b0, CFG_ZERO, '{6'h00, 16'h0000, 16'h0000, 16'h0010, 16'h0020, 16'h0005,
                          8'h10, 8'h20, 8'h30, 8'h40}, 1'b1,
        '{16'h0000, 16'h0010, 16'h0000, 16'h0020, 8'h10, 8'h30, 8'h20, 8'h40,
          16'h0005, 16'h0001}},
      '{1'b0, CFG_ZERO, PART_MAX, 1'b1,
        '{16'h7FFF, 16'hFFFE, 16'h7FFF, 16'hFFFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          16'hFFFF, 16'h0001}},
      '{1'b0, CFG_ZERO, PART_MIN, 1'b1,
        '{16'h8000, 16'h0000, 16'h8000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          16'h0000, 16'h0001}},
      // vertical flip
      '{1'b0, CFG_ZERO, std_part(6'h01), 1'b1,
        '{16'h0000, 16'h0008, 16'h0000, 16'h0008, 8'h10, 8'h30, 8'h3F, 8'h1F,
          16'h0000, 16'h0001}},
      // horizontal flip
      '{1'b0, CFG_ZERO, std_part(6'h02), 1'b1,
        '{16'h0000, 16'h0008, 16'h0000, 16'h0008, 8'h2F, 8'h0F, 8'h20, 8'h40,
          16'h0000, 16'h0001}},
      // trim right
      '{1'b0, CFG_ZERO, std_part(6'h04), 1'b1,
        '{16'h0000, 16'h0007, 16'h0000, 16'h0008, 8'h10, 8'h2F, 8'h20, 8'h40,
          16'h0000, 16'h0001}},
      // trim bottom
      '{1'b0, CFG_ZERO, std_part(6'h08), 1'b1,
        '{16'h0000, 16'h0008, 16'h0000, 16'h0007, 8'h10, 8'h30, 8'h20, 8'h3F,
          16'h0000, 16'h0001}},
      // trim left moves the origin
      '{1'b0, CFG_ZERO, std_part(6'h10), 1'b1,
        '{16'h0001, 16'h0008, 16'h0000, 16'h0008, 8'h11, 8'h30, 8'h20, 8'h40,
          16'h0000, 16'h0001}},
      // trim top moves the origin
      '{1'b0, CFG_ZERO, std_part(6'h20), 1'b1,
        '{16'h0000, 16'h0008, 16'h0001, 16'h0008, 8'h10, 8'h30, 8'h21, 8'h40,
          16'h0000, 16'h0001}},
      // trim right under horizontal flip shifts x
      '{1'b0, CFG_ZERO, std_part(6'h06), 1'b1,
        '{16'h0001, 16'h0008, 16'h0000, 16'h0008, 8'h2E, 8'h0F, 8'h20, 8'h40,
          16'h0000, 16'h0001}},
      // trim top under vertical flip keeps y
      '{1'b0, CFG_ZERO, std_part(6'h21), 1'b1,
        '{16'h0000, 16'h0008, 16'h0000, 16'h0007, 8'h10, 8'h30, 8'h3F, 8'h20,
          16'h0000, 16'h0001}},
      // texture decrement wraps below zero
      '{1'b0, CFG_ZERO, '{6'h02, 16'h0000, 16'h0000, 16'h0008, 16'h0008, 16'h0000,
                          8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
        '{16'h0000, 16'h0008, 16'h0000, 16'h0008, 8'hFF, 8'hFF, 8'h00, 8'h00,
          16'h0000, 16'h0001}},
      '{1'b0, CFG_ZERO, std_part(6'h3F), 1'b0, '0},
      // palette and priority wrap
      '{1'b1, CFG_WRAP, '{6'h00, 16'h0000, 16'h0000, 16'h0008, 16'h0008, 16'hFFFF,
                          8'h10, 8'h20, 8'h30, 8'h40}, 1'b1,
        '{16'h0000, 16'h0008, 16'h0000, 16'h0008, 8'h10, 8'h30, 8'h20, 8'h40,
          16'h0000, 16'h0000}},
      '{1'b1, CFG_MIRROR, '{6'h00, 16'h000A, 16'h0003, 16'h0008, 16'h0008, 16'h0001,
                            8'h10, 8'h20, 8'h30, 8'h40}, 1'b0, '0},
      '{1'b0, CFG_MIRROR, std_part(6'h02), 1'b0, '0},
      '{1'b0, CFG_MIRROR, std_part(6'h3F), 1'b0, '0},
      '{1'b1, CFG_EDGE_MAX, PART_MAX, 1'b0, '0},
      '{1'b0, CFG_EDGE_MAX, PART_MIN, 1'b0, '0},
      '{1'b1, CFG_EDGE_MIN, PART_MAX, 1'b0, '0},
      '{1'b0, CFG_EDGE_MIN, '{6'h3F, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
                              8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [FLAGS_W-1:0]        req_part_flags = '0;
   logic signed [COORD_W-1:0] req_offset_x = '0;
   logic signed [COORD_W-1:0] req_offset_y = '0;
   logic signed [COORD_W-1:0] req_width = '0;
   logic signed [COORD_W-1:0] req_height = '0;
   logic [PAL_W-1:0]          req_palette_offset = '0;
   logic [TEX_W-1:0]          req_tex_left = '0;
   logic [TEX_W-1:0]          req_tex_top = '0;
   logic [TEX_W-1:0]          req_tex_right = '0;
   logic [TEX_W-1:0]          req_tex_bottom = '0;
   logic                      rsp_valid;
   logic [VTX_W-1:0]          rsp_vertex_index;
   logic signed [COORD_W-1:0] rsp_screen_x;
   logic signed [COORD_W-1:0] rsp_screen_y;
   logic [TEX_W-1:0]          rsp_tex_u;
   logic [TEX_W-1:0]          rsp_tex_v;
   logic [PAL_W-1:0]          rsp_palette_out;
   logic [PAL_W-1:0]          rsp_priority_out;
   logic                      rsp_quad_done;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   cfg_type     entity_cfg = '0;
   vertex_type  pending_vertices [$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   sprite_part_quad_setup i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_part_flags     (req_part_flags),
      .req_offset_x       (req_offset_x),
      .req_offset_y       (req_offset_y),
      .req_width          (req_width),
      .req_height         (req_height),
      .req_palette_offset (req_palette_offset),
      .req_tex_left       (req_tex_left),
      .req_tex_top        (req_tex_top),
      .req_tex_right      (req_tex_right),
      .req_tex_bottom     (req_tex_bottom),
      .rsp_valid          (rsp_valid),
      .rsp_vertex_index   (rsp_vertex_index),
      .rsp_screen_x       (rsp_screen_x),
      .rsp_screen_y       (rsp_screen_y),
      .rsp_tex_u          (rsp_tex_u),
      .rsp_tex_v          (rsp_tex_v),
      .rsp_palette_out    (rsp_palette_out),
      .rsp_priority_out   (rsp_priority_out),
      .rsp_quad_done      (rsp_quad_done),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Quad corners of one part under the given entity settings.
   function automatic corners_type setup_quad(part_rec_type p, cfg_type c);
      logic [COORD_W-1:0] dx, dy, w, h, x, y;
      logic [TEX_W-1:0]   u0, v0, u1, v1;
      logic               mirror;
      corners_type        q;
      dx = p.dx;
      dy = p.dy;
      w  = p.w;
      h  = p.h;
      u0 = p.tex_l;
      v0 = p.tex_t;
      u1 = p.tex_r;
      v1 = p.tex_b;
      if (p.flags[FLAG_TRIM_R]) begin
         w = w - 1'b1;
         if (p.flags[FLAG_HFLIP]) dx = dx + 1'b1;
         u1 = u1 - 1'b1;
      end
      if (p.flags[FLAG_TRIM_B]) begin
         h = h - 1'b1;
         if (p.flags[FLAG_VFLIP]) dy = dy + 1'b1;
         v1 = v1 - 1'b1;
      end
      if (p.flags[FLAG_TRIM_L]) begin
         w = w - 1'b1;
         if (!p.flags[FLAG_HFLIP]) dx = dx + 1'b1;
         u0 = u0 + 1'b1;
      end
      if (p.flags[FLAG_TRIM_T]) begin
         h = h - 1'b1;
         if (!p.flags[FLAG_VFLIP]) dy = dy + 1'b1;
         v0 = v0 + 1'b1;
      end
      x = c.faces_left ? c.origin_x - dx : c.origin_x + dx;
      y = c.origin_y + dy;
      if (c.faces_left) begin
         q.xl = x - w + 1'b1;
         q.xr = x + 1'b1;
      end else begin
         q.xl = x;
         q.xr = x + w;
      end
      q.yt = y;
      q.yb = y + h;
      mirror = p.flags[FLAG_HFLIP] | c.faces_left;
      q.ul = mirror ? u1 - 1'b1 : u0;
      q.ur = mirror ? u0 - 1'b1 : u1;
      q.vt = p.flags[FLAG_VFLIP] ? v1 - 1'b1 : v0;
      q.vb = p.flags[FLAG_VFLIP] ? v0 - 1'b1 : v1;
      q.pal  = c.palette_base + p.pal_ofs;
      q.prio = c.depth_base + 1'b1;
      return q;
   endfunction

   task automatic push_vertices(corners_type q);
      vertex_type vtx;
      int         k;
      for (k = 0; k < 4; k++) begin
         vtx.idx  = VTX_W'(k);
         vtx.x    = k[0] ? q.xr : q.xl;
         vtx.y    = k[1] ? q.yb : q.yt;
         vtx.u    = k[0] ? q.ur : q.ul;
         vtx.v    = k[1] ? q.vb : q.vt;
         vtx.pal  = q.pal;
         vtx.prio = q.prio;
         vtx.done = (vtx.idx == VTX_LAST);
         pending_vertices.push_back(vtx);
      end
   endtask

   // Hold start low for the gap, then present the part until it is taken.
   task automatic send_part(part_rec_type p, int unsigned gap, logic typed,
                            corners_type want);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_part_flags     <= p.flags;
      req_offset_x       <= p.dx;
      req_offset_y       <= p.dy;
      req_width          <= p.w;
      req_height         <= p.h;
      req_palette_offset <= p.pal_ofs;
      req_tex_left       <= p.tex_l;
      req_tex_top        <= p.tex_t;
      req_tex_right      <= p.tex_r;
      req_tex_bottom     <= p.tex_b;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      push_vertices(typed ? want : setup_quad(p, entity_cfg));
   endtask

   task automatic drain_vertices();
      start <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write every register, plus junk to an unmapped index, then go quiet.
   task automatic program_entity(cfg_type c);
      csr_write(CSR_ORIGIN_X, c.origin_x);
      csr_write(CSR_ORIGIN_Y, c.origin_y);
      csr_write(CSR_FACES_LEFT, {15'($urandom), c.faces_left});
      csr_write(CSR_PALETTE_BASE, c.palette_base);
      csr_write(CSR_DEPTH_BASE, c.depth_base);
      csr_write(CSR_IDX_W'(CSR_DEPTH_BASE + $urandom_range(1, 3)), 16'($urandom));
      csr_we <= 1'b0;
      entity_cfg = c;
   endtask

   function automatic logic [COORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: rand_word = 16'h7FFF;
         1: rand_word = 16'h8000;
         2: rand_word = 16'h0000;
         3: rand_word = 16'hFFFF;
         4: rand_word = 16'($urandom_range(0, 64)) - 16'd32;
         default: rand_word = 16'($urandom);
      endcase
   endfunction

   function automatic logic [TEX_W-1:0] rand_texel();
      case ($urandom_range(0, 5))
         0: rand_texel = 8'h00;
         1: rand_texel = 8'hFF;
         2: rand_texel = 8'h01;
         default: rand_texel = 8'($urandom);
      endcase
   endfunction

   function automatic part_rec_type random_part();
      part_rec_type p;
      p.flags   = FLAGS_W'($urandom);
      p.dx      = rand_word();
      p.dy      = rand_word();
      p.w       = rand_word();
      p.h       = rand_word();
      p.pal_ofs = rand_word();
      p.tex_l   = rand_texel();
      p.tex_t   = rand_texel();
      p.tex_r   = rand_texel();
      p.tex_b   = rand_texel();
      return p;
   endfunction

   function automatic cfg_type phase_entity(int unsigned phase);
      cfg_type c;
      case (phase)
         0: c = CFG_EDGE_MAX;
         1: c = CFG_EDGE_MIN;
         default: begin
            c.origin_x     = rand_word();
            c.origin_y     = rand_word();
            c.faces_left   = phase[0];
            c.palette_base = rand_word();
            c.depth_base   = rand_word();
         end
      endcase
      return c;
   endfunction

   always @(posedge clock) begin : check_vertices
      vertex_type got, want;
      if (!reset && rsp_valid === 1'b1) begin
         got = '{rsp_vertex_index, rsp_screen_x, rsp_screen_y, rsp_tex_u, rsp_tex_v,
                 rsp_palette_out, rsp_priority_out, rsp_quad_done};
         if (pending_vertices.size() == 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < REPORT_LIMIT)
               $display("unexpected vertex transaction: idx=%0d x=%h y=%h", got.idx, got.x,
                        got.y);
         end else begin
            want = pending_vertices.pop_front();
            if (got !== want) begin
               fail_count <= fail_count + 1;
               if (fail_count < REPORT_LIMIT) begin
                  $display("vertex mismatch exp: idx=%0d x=%h y=%h u=%h v=%h %s",
                           want.idx, want.x, want.y, want.u, want.v,
                           $sformatf("pal=%h prio=%h done=%b", want.pal, want.prio,
                                     want.done));
                  $display("                got: idx=%0d x=%h y=%h u=%h v=%h %s",
                           got.idx, got.x, got.y, got.u, got.v,
                           $sformatf("pal=%h prio=%h done=%b", got.pal, got.prio,
                                     got.done));
               end
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned i, phase, n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) begin
         if (DIRECTED_ROWS[i].set_cfg) begin
            drain_vertices();
            program_entity(DIRECTED_ROWS[i].cfg);
         end
         send_part(DIRECTED_ROWS[i].part, $urandom_range(0, MAX_GAP),
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      // Odd phases stream back to back; even phases idle at random.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_vertices();
         program_entity(phase_entity(phase));
         for (n = 0; n < PARTS_PER_PHASE; n++)
            send_part(random_part(), phase[0] ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
      end

      drain_vertices();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
